// ----- hw/rtl/udb_pkg.sv -----
`timescale 1ns / 1ps

package udb_pkg;

  localparam int unsigned BaudBitsDefault = 16;
  localparam int unsigned CfgW            = 16;
  localparam int unsigned CfgIdxW         = 3;
  localparam int unsigned InTdataW        = 8;
  localparam int unsigned InTuserW        = 3;
  localparam int unsigned OutTdataW       = 24;
  localparam int unsigned TxcClearBit     = 6;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_READ     = 3'd1,
    MODE_WRITE    = 3'd2,
    MODE_STATUS   = 3'd3,
    MODE_RX_BYTE  = 3'd4,
    MODE_TXC_ACK  = 3'd5
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BAUD_TICKS   = 3'd0,
    CFG_DOUBLE_SPEED = 3'd1,
    CFG_TX_ENABLE    = 3'd2,
    CFG_RX_ENABLE    = 3'd3,
    CFG_TXC_INT_EN   = 3'd4,
    CFG_DRE_INT_EN   = 3'd5,
    CFG_RXC_INT_EN   = 3'd6
  } cfg_idx_e;

  // packed lowest field last so that read_data lands in the low byte
  typedef struct packed {
    logic       rxc_irq;
    logic       dre_irq;
    logic       txc_irq;
    logic       rx_accepted;
    logic       rx_complete;
    logic       tx_complete;
    logic       data_empty;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [7:0] read_data;
  } result_t;

endpackage

// ----- hw/rtl/uart_double_buffered_tx_rx_unit.sv -----
`timescale 1ns / 1ps
// UART data path with double-buffered transmitter and baud countdowns.
// Input channel (s_axis): one beat per event -- tick, data read, data
// write, status write, received byte or TXC acknowledge. tuser carries
// mode in [2:0], tdata carries data_in in [7:0].
// Output channel (m_axis): exactly one result beat per input beat, in
// order, reporting data register, finished TX byte, flags and IRQ levels
// as they stand after the event.
// Config port: cfg_we_i writes register cfg_idx_i with cfg_data_i;
// write only while no beat is in flight.
// The result is registered in the output stage before it shows on
// m_axis. Throughput: one beat per cycle while the sink does not stall;
// the event decode and next-state logic is a single combinational pass
// into the state and result registers.
// Reset clears all state, configuration and both output stages.
// When the sink stalls, a two-entry output stage absorbs one extra beat;
// s_axis_tready drops only while both entries are full.
module uart_double_buffered_tx_rx_unit import udb_pkg::*; #(
  parameter int unsigned BAUD_BITS = BaudBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] data_in
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // [2:0] mode
  input  logic [InTuserW-1:0]  s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] read_data, [8] tx_valid, [16:9] tx_byte, [17] data_empty,
  // [18] tx_complete, [19] rx_complete, [20] rx_accepted, [21] txc_irq,
  // [22] dre_irq, [23] rxc_irq
  output logic [OutTdataW-1:0] m_axis_tdata
);

  logic    beat;
  result_t res;

  assign beat = s_axis_tvalid && s_axis_tready;

  udb_core #(
    .BAUD_BITS(BAUD_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .beat_i    (beat),
    .mode_i    (s_axis_tuser),
    .data_in_i (s_axis_tdata),
    .res_o     (res)
  );

  udb_skid #(
    .W(OutTdataW)
  ) u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ----- hw/rtl/udb_skid.sv -----
`timescale 1ns / 1ps

module udb_skid #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [W-1:0] in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [W-1:0] out_data_o
);

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  logic [W-1:0] out_q, out_d;
  logic [W-1:0] skid_q, skid_d;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d = 1'b1;
        out_d       = skid_q;
      end else begin
        out_valid_d = in_valid_i;
        out_d       = in_data_i;
      end
      skid_valid_d = 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid beat held without output beat");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("stalled output beat changed");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_ready_i |=> skid_valid_q && $stable(skid_q))
    else $error("skid beat lost under stall");

endmodule

// ----- hw/rtl/udb_core.sv -----
`timescale 1ns / 1ps

module udb_core import udb_pkg::*; #(
  parameter int unsigned BAUD_BITS = BaudBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               beat_i,
  input  logic [2:0]         mode_i,
  input  logic [7:0]         data_in_i,
  output result_t            res_o
);

  logic [15:0] baud_ticks_q;
  logic        double_speed_q, tx_en_q, rx_en_q, txc_ie_q, dre_ie_q, rxc_ie_q;

  logic [7:0]           data_reg_q, data_reg_d;
  logic [7:0]           hold_buf_q, hold_buf_d;
  logic                 hold_full_q, hold_full_d;
  logic [7:0]           shift_tx_q, shift_tx_d;
  logic                 shift_full_q, shift_full_d;
  logic [BAUD_BITS-1:0] tx_cnt_q, tx_cnt_d;
  logic [7:0]           shift_rx_q, shift_rx_d;
  logic [BAUD_BITS-1:0] rx_cnt_q, rx_cnt_d;
  logic                 txc_q, txc_d;
  logic                 rxc_q, rxc_d;

  logic [BAUD_BITS-1:0] tx_load, rx_load, tx_dec, rx_dec;
  logic                 done;
  logic [7:0]           done_byte;
  logic                 accepted;
  mode_e                mode;

  assign mode    = mode_e'(mode_i);
  assign tx_load = BAUD_BITS'(double_speed_q ? {1'b0, baud_ticks_q[15:1]} : baud_ticks_q);
  assign rx_load = BAUD_BITS'(baud_ticks_q);
  assign tx_dec  = tx_cnt_q - 1'b1;
  assign rx_dec  = rx_cnt_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baud_ticks_q   <= '0;
      double_speed_q <= 1'b0;
      tx_en_q        <= 1'b0;
      rx_en_q        <= 1'b0;
      txc_ie_q       <= 1'b0;
      dre_ie_q       <= 1'b0;
      rxc_ie_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BAUD_TICKS:   baud_ticks_q   <= cfg_data_i[15:0];
        CFG_DOUBLE_SPEED: double_speed_q <= cfg_data_i[0];
        CFG_TX_ENABLE:    tx_en_q        <= cfg_data_i[0];
        CFG_RX_ENABLE:    rx_en_q        <= cfg_data_i[0];
        CFG_TXC_INT_EN:   txc_ie_q       <= cfg_data_i[0];
        CFG_DRE_INT_EN:   dre_ie_q       <= cfg_data_i[0];
        CFG_RXC_INT_EN:   rxc_ie_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    data_reg_d   = data_reg_q;
    hold_buf_d   = hold_buf_q;
    hold_full_d  = hold_full_q;
    shift_tx_d   = shift_tx_q;
    shift_full_d = shift_full_q;
    tx_cnt_d     = tx_cnt_q;
    shift_rx_d   = shift_rx_q;
    rx_cnt_d     = rx_cnt_q;
    txc_d        = txc_q;
    rxc_d        = rxc_q;
    done         = 1'b0;
    done_byte    = '0;
    accepted     = 1'b0;
    unique case (mode)
      MODE_TICK: begin
        if (tx_en_q && tx_cnt_q != '0) begin
          tx_cnt_d = tx_dec;
          if (tx_dec == '0) begin
            done      = 1'b1;
            done_byte = shift_tx_q;
            hold_buf_d  = '0;
            hold_full_d = 1'b0;
            if (hold_full_q) begin
              shift_tx_d   = hold_buf_q;
              shift_full_d = 1'b1;
              tx_cnt_d     = tx_load;
            end else begin
              shift_tx_d   = '0;
              shift_full_d = 1'b0;
              txc_d        = 1'b1;
            end
          end
        end
        if (rx_en_q && rx_cnt_q != '0) begin
          rx_cnt_d = rx_dec;
          if (rx_dec == '0) begin
            data_reg_d = shift_rx_q;
            shift_rx_d = '0;
            rxc_d      = 1'b1;
          end
        end
      end
      MODE_READ: rxc_d = 1'b0;
      MODE_WRITE: begin
        data_reg_d = data_in_i;
        if (tx_en_q) begin
          if (tx_cnt_q == '0) tx_cnt_d = tx_load;
          if (!shift_full_q) begin
            shift_tx_d   = data_in_i;
            shift_full_d = 1'b1;
            hold_buf_d   = '0;
            hold_full_d  = 1'b0;
          end else begin
            hold_buf_d  = data_in_i;
            hold_full_d = 1'b1;
          end
        end
      end
      MODE_STATUS: begin
        if (data_in_i[TxcClearBit]) txc_d = 1'b0;
      end
      MODE_RX_BYTE: begin
        if (rx_en_q && rx_cnt_q == '0) begin
          shift_rx_d = data_in_i;
          rx_cnt_d   = rx_load;
          accepted   = 1'b1;
        end
      end
      MODE_TXC_ACK: txc_d = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    res_o.read_data   = data_reg_d;
    res_o.tx_valid    = done;
    res_o.tx_byte     = done_byte;
    res_o.data_empty  = !hold_full_d;
    res_o.tx_complete = txc_d;
    res_o.rx_complete = rxc_d;
    res_o.rx_accepted = accepted;
    res_o.txc_irq     = txc_ie_q && txc_d;
    res_o.dre_irq     = dre_ie_q && !hold_full_d;
    res_o.rxc_irq     = rxc_ie_q && rxc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_reg_q   <= '0;
      hold_buf_q   <= '0;
      hold_full_q  <= 1'b0;
      shift_tx_q   <= '0;
      shift_full_q <= 1'b0;
      tx_cnt_q     <= '0;
      shift_rx_q   <= '0;
      rx_cnt_q     <= '0;
      txc_q        <= 1'b0;
      rxc_q        <= 1'b0;
    end else if (beat_i) begin
      data_reg_q   <= data_reg_d;
      hold_buf_q   <= hold_buf_d;
      hold_full_q  <= hold_full_d;
      shift_tx_q   <= shift_tx_d;
      shift_full_q <= shift_full_d;
      tx_cnt_q     <= tx_cnt_d;
      shift_rx_q   <= shift_rx_d;
      rx_cnt_q     <= rx_cnt_d;
      txc_q        <= txc_d;
      rxc_q        <= rxc_d;
    end
  end

  a_hold_needs_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_full_q |-> shift_full_q)
    else $error("holding buffer full with empty shift register");

  a_hold_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hold_full_q |-> hold_buf_q == '0)
    else $error("empty holding buffer not cleared");

  a_shift_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !shift_full_q |-> shift_tx_q == '0)
    else $error("empty shift register not cleared");

  a_done_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && res_o.tx_valid |=> shift_full_q || txc_q)
    else $error("finished byte left neither reload nor TXC");

endmodule
